// ===== rtl/core/pce_pkg.sv =====
`timescale 1ns / 1ps
// pce_pkg: shared types and constants of the polynomial coefficient evaluator
// depends on nothing; used by pce_ctrl, pce_datapath and the top level

package pce_pkg;

    localparam int ACC_W   = 48;
    localparam int PROD_W  = 64;
    localparam int X_W     = 16;
    localparam int IN_C_W  = 16;
    localparam int POW_W   = 4;
    localparam int OUT_W   = 32;
    localparam int FRAC_SH = 12;
    localparam int COEF_SH = 8;
    localparam int SPLIT   = 24;

    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic wr_en;
        logic mul_en;
        logic acc_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/pce_ctrl.sv =====
`timescale 1ns / 1ps
// pce_ctrl: sequencer for set and evaluate beats, walks the exponent down
// depends on pce_pkg

module pce_ctrl #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_kind,
    output logic                                   in_ready,
    input  pce_pkg::status_t                       status,
    output pce_pkg::cmd_t                          cmd,
    output logic [$clog2(MAX_DEGREE + 1) - 1:0]    rd_addr
);

    localparam int AW = $clog2(MAX_DEGREE + 1);
    localparam logic [AW - 1:0] TOP = AW'(MAX_DEGREE);

    pce_pkg::state_t state_reg, state_next;
    logic [AW - 1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pce_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pce_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == pce_pkg::REQ_EVAL)
                    begin
                        cmd.start  = 1'b1;
                        k_next     = TOP;
                        state_next = pce_pkg::ST_MUL;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            pce_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = pce_pkg::ST_ACC;
            end
            pce_pkg::ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (k_reg == '0)
                begin
                    state_next = pce_pkg::ST_DONE;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = pce_pkg::ST_MUL;
                end
            end
            pce_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pce_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_addr = k_reg;

endmodule

// ===== rtl/core/pce_datapath.sv =====
`timescale 1ns / 1ps
// pce_datapath: coefficient store, split multiplier, rounding, saturation, output register
// depends on pce_pkg

module pce_datapath #(
    parameter int MAX_DEGREE = 15,
    parameter int COEF_BITS  = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  pce_pkg::cmd_t                               cmd,
    output pce_pkg::status_t                            status,
    input  logic [$clog2(MAX_DEGREE + 1) - 1:0]         rd_addr,
    input  logic [pce_pkg::POW_W - 1:0]                 term_power,
    input  logic signed [pce_pkg::IN_C_W - 1:0]         term_coeff,
    input  logic signed [pce_pkg::X_W - 1:0]            point_x,
    output logic signed [pce_pkg::OUT_W - 1:0]          poly_value,
    output logic                                        overflow_flag,
    output logic                                        out_valid,
    input  logic                                        out_ready
);

    localparam int AW    = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AccW  = pce_pkg::ACC_W;
    localparam int PW    = pce_pkg::PROD_W;
    localparam int SP    = pce_pkg::SPLIT;
    localparam int XW    = pce_pkg::X_W;
    localparam int HI_W  = AccW - SP + XW;
    localparam int LO_W  = SP + 1 + XW;
    localparam int OW    = pce_pkg::OUT_W;
    localparam logic signed [32:0] C_MAX = (33'sd1 <<< (COEF_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] C_MIN = -C_MAX - 33'sd1;

    // coefficient store, entries read as zero until written
    logic [COEF_BITS - 1:0] mem [DEPTH];
    logic [DEPTH - 1:0]     valid_reg;
    logic [COEF_BITS - 1:0] rd_data_reg;
    logic                   rd_valid_reg;

    logic [AW + pce_pkg::POW_W - 1:0] pow_ext;
    logic [AW - 1:0]                  wr_addr;
    logic                             wr_ok;
    logic signed [32:0]               c_in;
    logic signed [32:0]               c_clamp;

    assign pow_ext = {{AW{1'b0}}, term_power};
    assign wr_addr = pow_ext[AW - 1:0];
    assign wr_ok   = cmd.wr_en && (pow_ext <= (AW + pce_pkg::POW_W)'(MAX_DEGREE));
    assign c_in    = {{(33 - pce_pkg::IN_C_W){term_coeff[pce_pkg::IN_C_W - 1]}}, term_coeff};

    always_comb
    begin
        if (c_in > C_MAX)
        begin
            c_clamp = C_MAX;
        end
        else if (c_in < C_MIN)
        begin
            c_clamp = C_MIN;
        end
        else
        begin
            c_clamp = c_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= c_clamp[COEF_BITS - 1:0];
        end
        if (cmd.mul_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.mul_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // horner step: split product, then round, add and saturate
    logic signed [AccW - 1:0] acc_reg;
    logic signed [XW - 1:0]   x_reg;
    logic                     ovf_reg;
    logic signed [HI_W - 1:0] pp_hi_reg;
    logic signed [LO_W - 1:0] pp_lo_reg;

    logic signed [PW - 1:0]        prod;
    logic signed [PW - 1:0]        rnd;
    logic signed [PW - 1:0]        coef_ext;
    logic signed [PW - 1:0]        sum;
    logic signed [COEF_BITS - 1:0] coef;
    logic signed [AccW - 1:0]      acc_sat;
    logic                          acc_ovf;

    assign coef = rd_valid_reg ? $signed(rd_data_reg) : '0;
    assign prod = ($signed({{(PW - HI_W){pp_hi_reg[HI_W - 1]}}, pp_hi_reg}) <<< SP)
                + $signed({{(PW - LO_W){pp_lo_reg[LO_W - 1]}}, pp_lo_reg});
    assign rnd  = (prod + 64'sd2048) >>> pce_pkg::FRAC_SH;
    assign coef_ext = $signed({{(PW - COEF_BITS){coef[COEF_BITS - 1]}}, coef})
                    <<< pce_pkg::COEF_SH;
    assign sum  = rnd + coef_ext;

    always_comb
    begin
        acc_ovf = 1'b0;
        acc_sat = sum[AccW - 1:0];
        if (sum[PW - 1:AccW - 1] != {(PW - AccW + 1){sum[PW - 1]}})
        begin
            acc_ovf = 1'b1;
            acc_sat = sum[PW - 1] ? {1'b1, {(AccW - 1){1'b0}}} : {1'b0, {(AccW - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_hi_reg <= $signed(acc_reg[AccW - 1:SP]) * x_reg;
            pp_lo_reg <= $signed({1'b0, acc_reg[SP - 1:0]}) * x_reg;
        end
        if (cmd.start)
        begin
            x_reg <= point_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_sat;
            ovf_reg <= ovf_reg | acc_ovf;
        end
    end

    // final narrowing to q16.16 and output register
    logic signed [OW - 1:0] fin_val;
    logic                   fin_ovf;
    logic signed [OW - 1:0] out_val_reg;
    logic                   out_ovf_reg;
    logic                   out_valid_reg;

    always_comb
    begin
        fin_ovf = 1'b0;
        fin_val = acc_reg[OW - 1:0];
        if (acc_reg[AccW - 1:OW - 1] != {(AccW - OW + 1){acc_reg[AccW - 1]}})
        begin
            fin_ovf = 1'b1;
            fin_val = acc_reg[AccW - 1] ? {1'b1, {(OW - 1){1'b0}}} : {1'b0, {(OW - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_val_reg <= fin_val;
            out_ovf_reg <= ovf_reg | fin_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign poly_value      = out_val_reg;
    assign overflow_flag   = out_ovf_reg;

endmodule

// ===== rtl/core/polynomial_coefficient_evaluator.sv =====
`timescale 1ns / 1ps
// evaluate beat: the result follows one horner step per coefficient, each step going through
// the split multiplier and then the round/add/saturate stage
// next beat taken once an evaluate result is loaded, and in the following cycle after a set beat
// result waits in an output register while set beats keep being taken
// async active-low reset clears control state and marks every coefficient as zero
// depends on pce_pkg, pce_ctrl, pce_datapath

module polynomial_coefficient_evaluator #(
    parameter int MAX_DEGREE = 15,
    parameter int COEF_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // term_power[3:0], term_coeff[19:4], point_x[35:20], zero pad
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // poly_value[31:0]
    output logic        m_axis_tuser    // overflow_flag
);

    localparam int AW = $clog2(MAX_DEGREE + 1);

    pce_pkg::cmd_t    cmd;
    pce_pkg::status_t status;
    logic [AW - 1:0]  rd_addr;
    logic signed [pce_pkg::OUT_W - 1:0] poly_value;

    pce_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    pce_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_BITS  (COEF_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rd_addr       (rd_addr),
        .term_power    (s_axis_tdata[3:0]),
        .term_coeff    ($signed(s_axis_tdata[19:4])),
        .point_x       ($signed(s_axis_tdata[35:20])),
        .poly_value    (poly_value),
        .overflow_flag (m_axis_tuser),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready)
    );

    assign m_axis_tdata = poly_value;

endmodule
